[rtl/asidal_pkg.sv]
package asidal_pkg;

    // default number of identifiers handed out
    localparam int NUM_IDS_DEF = 128;

    // identifier code that means no address space assigned
    localparam logic [7:0] ASID_NONE = 8'd254;

    // command codes
    localparam logic CMD_SWITCH  = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // usage mark of one identifier
    typedef enum logic [1:0] {
        MARK_FREE  = 2'd0,
        MARK_USED  = 2'd1,
        MARK_DIRTY = 2'd2
    } mark_t;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

endpackage

[rtl/asid_allocator_lazy_flush_unit.sv]
// asid allocator with deferred tlb flush
//
// input channel (in_valid/in_ready, cmd, asid_in) takes one request per transfer;
// output channel (out_valid/out_ready, asid_out, flush_tlb, status) returns one
// result per request. in_ready is high only while the sequencer is idle, so
// one request is worked on at a time.
//
// switch with an assigned id and every release go straight to the output
// state. switch with the invalid code runs a find pass over the mark memory,
// one entry read per cycle on its single read port, which the lowest free id
// ends early. with no free id a reclaim pass turns dirty marks free, then the
// highest reclaimed id is taken with flush_tlb set; with no dirty mark either,
// the result is the invalid code with status exhausted.
//
// reset clears the per-entry valid flags, so every mark reads as free with no
// clearing pass. the result sits in an output register; when the receiver
// stalls, a finished result waits there and the sequencer holds in its
// output state until the register is free.
module asid_allocator_lazy_flush_unit
    import asidal_pkg::*;
#(
    parameter int NUM_IDS = NUM_IDS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] asid_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] asid_out,
    output logic       flush_tlb,
    output logic [1:0] status
);

    localparam int IW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int CW = $clog2(NUM_IDS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_RECLAIM,
        S_FINAL,
        S_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            rd_live_reg, rd_live_next;
    logic [IW-1:0]   pick_reg, pick_next;
    logic            found_reg, found_next;
    logic [7:0]      res_asid_reg, res_asid_next;
    logic            res_flush_reg, res_flush_next;
    logic [1:0]      res_status_reg, res_status_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      asid_out_reg, asid_out_next;
    logic            flush_tlb_reg, flush_tlb_next;
    logic [1:0]      status_reg, status_next;

    // mark memory, one read and one write port
    mark_t           marks_mem [NUM_IDS];
    logic [NUM_IDS-1:0] valid_reg;
    mark_t           rd_mark_reg;
    logic            rd_flag_reg;
    logic [IW-1:0]   rd_addr_reg;
    logic [IW-1:0]   rd_addr;
    mark_t           eff_mark;

    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    mark_t           mem_wd;

    logic            scan_more;
    logic            scan_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign asid_out  = asid_out_reg;
    assign flush_tlb = flush_tlb_reg;
    assign status    = status_reg;

    assign rd_addr   = cnt_reg[IW-1:0];
    // an entry never written since reset is free
    assign eff_mark  = rd_flag_reg ? rd_mark_reg : MARK_FREE;
    assign scan_more = (cnt_reg < CW'(NUM_IDS));
    assign scan_last = (cnt_reg == CW'(NUM_IDS));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            marks_mem[mem_wa] <= mem_wd;
        end
        rd_mark_reg <= marks_mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_flag_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[mem_wa] <= 1'b1;
            end
            rd_flag_reg <= valid_reg[rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_live_next    = rd_live_reg;
        pick_next       = pick_reg;
        found_next      = found_reg;
        res_asid_next   = res_asid_reg;
        res_flush_next  = res_flush_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        asid_out_next   = asid_out_reg;
        flush_tlb_next  = flush_tlb_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_wa          = rd_addr_reg;
        mem_wd          = MARK_USED;

        // output transfer frees the register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_flush_next = 1'b0;
                    state_next     = S_OUT;
                    if (cmd == CMD_SWITCH)
                    begin
                        if (asid_in == ASID_NONE)
                        begin
                            // start the find pass
                            state_next   = S_FIND;
                            cnt_next     = '0;
                            rd_live_next = 1'b0;
                            found_next   = 1'b0;
                        end
                        else
                        begin
                            // already assigned, pass through
                            res_asid_next   = asid_in;
                            res_status_next = ST_OK;
                        end
                    end
                    else if (asid_in >= 8'(NUM_IDS))
                    begin
                        res_asid_next   = ASID_NONE;
                        res_status_next = ST_RANGE;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        mem_wa          = asid_in[IW-1:0];
                        mem_wd          = MARK_DIRTY;
                        res_asid_next   = ASID_NONE;
                        res_status_next = ST_OK;
                    end
                end
            end

            S_FIND:
            begin
                rd_live_next = scan_more;
                if (scan_more)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (rd_live_reg && (eff_mark == MARK_FREE))
                begin
                    // lowest free id
                    mem_we          = 1'b1;
                    mem_wa          = rd_addr_reg;
                    mem_wd          = MARK_USED;
                    res_asid_next   = 8'(rd_addr_reg);
                    res_flush_next  = 1'b0;
                    res_status_next = ST_OK;
                    state_next      = S_OUT;
                end
                else if (scan_last)
                begin
                    state_next   = S_RECLAIM;
                    cnt_next     = '0;
                    rd_live_next = 1'b0;
                end
            end

            S_RECLAIM:
            begin
                rd_live_next = scan_more;
                if (scan_more)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (rd_live_reg && (eff_mark == MARK_DIRTY))
                begin
                    // dirty back to free, remember the highest
                    mem_we     = 1'b1;
                    mem_wa     = rd_addr_reg;
                    mem_wd     = MARK_FREE;
                    pick_next  = rd_addr_reg;
                    found_next = 1'b1;
                end
                if (scan_last)
                begin
                    state_next = S_FINAL;
                end
            end

            S_FINAL:
            begin
                state_next = S_OUT;
                if (found_reg)
                begin
                    mem_we          = 1'b1;
                    mem_wa          = pick_reg;
                    mem_wd          = MARK_USED;
                    res_asid_next   = 8'(pick_reg);
                    res_flush_next  = 1'b1;
                    res_status_next = ST_OK;
                end
                else
                begin
                    res_asid_next   = ASID_NONE;
                    res_flush_next  = 1'b0;
                    res_status_next = ST_EXHAUSTED;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    asid_out_next  = res_asid_reg;
                    flush_tlb_next = res_flush_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            rd_live_reg    <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_live_reg    <= rd_live_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        pick_reg       <= pick_next;
        res_asid_reg   <= res_asid_next;
        res_flush_reg  <= res_flush_next;
        res_status_reg <= res_status_next;
        asid_out_reg   <= asid_out_next;
        flush_tlb_reg  <= flush_tlb_next;
        status_reg     <= status_next;
    end

endmodule

[tb/asid_allocator_lazy_flush_checker.sv]
module asid_allocator_lazy_flush_checker
    import asidal_pkg::*;
#(
    parameter int NUM_IDS = NUM_IDS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] asid_in,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] asid_out,
    input  logic       flush_tlb,
    input  logic [1:0] status,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] asid;
        logic       flush;
        logic [1:0] status;
    } grant_t;

    mark_t  id_marks [NUM_IDS];
    grant_t pending_grants [$];

    // allocation policy: lowest free id, else reclaim every dirty id and take the highest
    function automatic grant_t predict_grant(logic req_cmd, logic [7:0] req_id);
        grant_t g;
        int     pick;
        bit     reclaimed;
        g = '{asid: ASID_NONE, flush: 1'b0, status: ST_OK};
        pick = -1;
        reclaimed = 1'b0;
        if (req_cmd == CMD_SWITCH)
        begin
            if (req_id != ASID_NONE)
            begin
                g.asid = req_id;
            end
            else
            begin
                for (int k = 0; k < NUM_IDS; k++)
                begin
                    if (pick < 0 && id_marks[k] == MARK_FREE)
                        pick = k;
                end
                if (pick < 0)
                begin
                    for (int k = 0; k < NUM_IDS; k++)
                    begin
                        if (id_marks[k] == MARK_DIRTY)
                        begin
                            id_marks[k] = MARK_FREE;
                            pick = k;
                            reclaimed = 1'b1;
                        end
                    end
                end
                if (pick < 0)
                begin
                    g.status = ST_EXHAUSTED;
                end
                else
                begin
                    id_marks[pick] = MARK_USED;
                    g.asid = 8'(pick);
                    g.flush = reclaimed;
                end
            end
        end
        else
        begin
            if (int'(req_id) >= NUM_IDS)
                g.status = ST_RANGE;
            else
                id_marks[req_id] = MARK_DIRTY;
        end
        return g;
    endfunction

    initial
    begin
        fail_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_IDS; k++)
                id_marks[k] = MARK_FREE;
            pending_grants.delete();
            pending <= 0;
        end
        else
        begin
            // older request's result first
            if (out_valid && out_ready)
            begin
                if (pending_grants.size() == 0)
                begin
                    $display("%0t: unexpected result asid_out %0d flush_tlb %0d status %0d",
                             $time, asid_out, flush_tlb, status);
                    fail_count++;
                end
                else
                begin
                    want = pending_grants.pop_front();
                    if (asid_out !== want.asid || flush_tlb !== want.flush
                        || status !== want.status)
                    begin
                        $display("%0t: mismatch asid_out exp %0d got %0d", $time,
                                 want.asid, asid_out);
                        $display("%0t: mismatch flush_tlb exp %0d got %0d", $time,
                                 want.flush, flush_tlb);
                        $display("%0t: mismatch status exp %0d got %0d", $time,
                                 want.status, status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                pending_grants.push_back(predict_grant(cmd, asid_in));
            pending <= pending_grants.size();
        end
    end

endmodule

[tb/tb_asid_allocator_lazy_flush_unit.sv]
module tb_asid_allocator_lazy_flush_unit;
    import asidal_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_IDS        = NUM_IDS_DEF;
    localparam int RANDOM_ITEMS   = 700;
    // worst request is about two table passes, plus the longest stall on either side
    localparam int STALL_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 300;

    typedef enum {
        EP_FILL,
        EP_RELEASE,
        EP_MIXED,
        EP_NOISE,
        EP_DRAIN
    } episode_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       cmd;
    logic [7:0] asid_in;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] asid_out;
    logic       flush_tlb;
    logic [1:0] status;

    int fail_count;
    int pending;
    int items_sent;
    int idle_cycles;
    bit steady_flow;

    asid_allocator_lazy_flush_unit #(
        .NUM_IDS (NUM_IDS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .asid_in   (asid_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .asid_out  (asid_out),
        .flush_tlb (flush_tlb),
        .status    (status)
    );

    // watches both channels, predicts every grant and compares
    asid_allocator_lazy_flush_checker #(
        .NUM_IDS (NUM_IDS)
    ) i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .asid_in    (asid_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .asid_out   (asid_out),
        .flush_tlb  (flush_tlb),
        .status     (status),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // free-running clock, 10 ns period
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle length: mostly none or short, now and then long; none at all in steady stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // one request transfer; called at a falling edge, returns at the falling edge after it
    task automatic send_request(input logic req_cmd, input logic [7:0] req_id);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= req_cmd;
        asid_in  <= req_id;
        // hold until the block takes it
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    // sender holds off until every expected grant has come back
    task automatic wait_for_grants();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] in_range_id();
        return 8'($urandom_range(0, NUM_IDS - 1));
    endfunction

    function automatic logic [7:0] out_of_range_id();
        return 8'($urandom_range(NUM_IDS, 255));
    endfunction

    // receiver side: random stalls on out_ready, one update per falling edge
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** asid_allocator_lazy_flush_unit: FAILED **");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin
        episode_t kind;
        int       len;
        int       r;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cmd         = CMD_SWITCH;
        asid_in     = 8'd0;
        items_sent  = 0;
        idle_cycles = 0;
        steady_flow = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: release edges, including out of range and the none code
        send_request(CMD_RELEASE, 8'd0);
        send_request(CMD_RELEASE, 8'(NUM_IDS - 1));
        send_request(CMD_RELEASE, 8'(NUM_IDS));
        send_request(CMD_RELEASE, ASID_NONE);
        send_request(CMD_RELEASE, 8'd255);
        // switch with an assigned id passes through, even out of range
        send_request(CMD_SWITCH, 8'd0);
        send_request(CMD_SWITCH, 8'd255);
        send_request(CMD_SWITCH, 8'(NUM_IDS - 1));
        send_request(CMD_SWITCH, 8'(NUM_IDS));
        send_request(CMD_SWITCH, 8'd253);
        send_request(CMD_SWITCH, 8'h55);
        send_request(CMD_SWITCH, 8'hAA);
        // fresh allocations take the lowest free id
        send_request(CMD_SWITCH, ASID_NONE);
        send_request(CMD_SWITCH, ASID_NONE);
        // release of a used id, of an already dirty one and of a free one
        send_request(CMD_RELEASE, 8'd1);
        send_request(CMD_RELEASE, 8'd1);
        send_request(CMD_RELEASE, 8'd3);
        wait_for_grants();
        send_request(CMD_SWITCH, ASID_NONE);
        send_request(CMD_RELEASE, 8'd2);
        send_request(CMD_SWITCH, ASID_NONE);
        wait_for_grants();

        // random episodes: fill runs reach reclaim and exhaustion, the rest churns the table
        while (items_sent < 20 + RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                kind = EP_FILL;
            else if (r < 5)
                kind = EP_RELEASE;
            else if (r < 8)
                kind = EP_MIXED;
            else if (r < 9)
                kind = EP_NOISE;
            else
                kind = EP_DRAIN;
            steady_flow = ($urandom_range(0, 4) == 0);
            case (kind)
                EP_FILL:
                begin
                    len = $urandom_range(16, 150);
                    repeat (len)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_request(CMD_SWITCH, 8'($urandom_range(0, 255)));
                        else
                            send_request(CMD_SWITCH, ASID_NONE);
                    end
                end
                EP_RELEASE:
                begin
                    len = $urandom_range(4, 40);
                    repeat (len)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_request(CMD_RELEASE, out_of_range_id());
                        else
                            send_request(CMD_RELEASE, in_range_id());
                    end
                end
                EP_MIXED:
                begin
                    len = $urandom_range(10, 60);
                    repeat (len)
                    begin
                        r = $urandom_range(0, 9);
                        if (r < 5)
                            send_request(CMD_SWITCH, ASID_NONE);
                        else if (r < 8)
                            send_request(CMD_RELEASE, in_range_id());
                        else
                            send_request(CMD_SWITCH, 8'($urandom_range(0, 255)));
                    end
                end
                EP_NOISE:
                begin
                    len = $urandom_range(5, 20);
                    repeat (len)
                        send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
                default:
                begin
                    wait_for_grants();
                end
            endcase
        end

        // all requests taken: let the last grants come back, then settle
        wait_for_grants();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** asid_allocator_lazy_flush_unit: PASSED **");
        else
            $display("** asid_allocator_lazy_flush_unit: FAILED **");
        $finish;
    end

endmodule
